>>> hdl/bfse_pkg.sv
// shared types and constants of the boolean formula stack evaluator
package bfse_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int NUM_VARS    = 64;
   localparam int VAR_W       = 64;
   localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_CONST = 3'd0,
      KIND_VAR   = 3'd1,
      KIND_NOT   = 3'd2,
      KIND_AND   = 3'd3,
      KIND_OR    = 3'd4,
      KIND_IMPL  = 3'd5,
      KIND_EQUIV = 3'd6,
      KIND_XOR   = 3'd7
   } node_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DEPTH = 2'd3
   } status_type;

   typedef struct packed {
      node_kind_type node_kind;
      logic          const_value;
      logic [5:0]    var_index;
      logic          last;
   } req_type;

   typedef struct packed {
      logic       value;
      status_type status;
   } rsp_type;

endpackage

>>> hdl/bfse_ram.sv
// generic single write port ram with registered read
module bfse_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/boolean_formula_stack_evaluator_top.sv
// top level: stack evaluator with ram-held stack, register-held top and output skid buffer
// one node accepted per cycle while the skid slot is empty
// result beat of the node marked last goes to the output register, or the skid slot if rsp stalls
// throughput set by the stack ram: one read and one write per cycle, top kept in a register
// reset clears depth, error, assignment register and output buffer
// stack ram is not cleared: read data from entries above the depth is never used
module boolean_formula_stack_evaluator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bfse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bfse_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [bfse_pkg::VAR_W-1:0] csr_data
);
   import bfse_pkg::*;

   logic [VAR_W-1:0]   var_values_ff;
   logic [DEPTH_W-1:0] depth_ff, depth_in, step_depth;
   status_type         err_ff, err_in, step_err;
   logic               top_ff, top_in;
   logic               fwd_use_ff, fwd_use_in;
   logic               fwd_bit_ff;
   logic               second;
   logic               ram_rdata;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic               accept, produce, leaf_bit, lhs, rhs, combined;
   logic [DEPTH_W-1:0] depth_m1, depth_m2;
   rsp_type            result;
   logic               out_valid_ff, skid_valid_ff, take;
   rsp_type            out_ff, skid_ff;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign second    = fwd_use_ff ? fwd_bit_ff : ram_rdata;
   assign depth_m1  = depth_ff - DEPTH_W'(1);

   always_comb begin
      leaf_bit = 1'b0;
      if ({1'b0, req_data.var_index} < 7'(NUM_VARS)) begin
         leaf_bit = var_values_ff[req_data.var_index];
      end
      if (req_data.node_kind == KIND_CONST) begin
         leaf_bit = req_data.const_value;
      end
   end

   always_comb begin
      lhs = top_ff;
      rhs = second;
      case (req_data.node_kind)
         KIND_AND:   combined = lhs & rhs;
         KIND_OR:    combined = lhs | rhs;
         KIND_IMPL:  combined = !lhs | rhs;
         KIND_EQUIV: combined = !(lhs ^ rhs);
         default:    combined = lhs ^ rhs;
      endcase
   end

   always_comb begin
      step_depth = depth_ff;
      step_err   = err_ff;
      top_in     = top_ff;
      wr_en      = 1'b0;
      wr_addr    = depth_m1[ADDR_W-1:0];
      produce    = 1'b0;
      result     = '{value: 1'b0, status: ST_OK};
      if (accept) begin
         case (req_data.node_kind)
            KIND_CONST, KIND_VAR: begin
               if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
                  if (err_ff == ST_OK) step_err = ST_OVER;
               end else begin
                  wr_en      = (depth_ff != '0);
                  top_in     = leaf_bit;
                  step_depth = depth_ff + DEPTH_W'(1);
               end
            end
            KIND_NOT: begin
               if (depth_ff == '0) begin
                  if (err_ff == ST_OK) step_err = ST_UNDER;
               end else begin
                  top_in = !top_ff;
               end
            end
            default: begin
               if (depth_ff < DEPTH_W'(2)) begin
                  if (err_ff == ST_OK) step_err = ST_UNDER;
               end else begin
                  top_in     = combined;
                  step_depth = depth_m1;
               end
            end
         endcase
         if (req_data.last) begin
            produce       = 1'b1;
            result.status = step_err;
            if (step_err == ST_OK) begin
               if (step_depth == DEPTH_W'(1)) begin
                  result.value = top_in;
               end else begin
                  result.status = ST_DEPTH;
               end
            end
         end
      end
      depth_in = produce ? '0 : step_depth;
      err_in   = produce ? ST_OK : step_err;
      depth_m2   = depth_in - DEPTH_W'(2);
      rd_addr    = depth_m2[ADDR_W-1:0];
      fwd_use_in = wr_en && (wr_addr == rd_addr);
   end

   bfse_ram #(
      .WIDTH(1),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(top_ff),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

   assign take      = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         var_values_ff <= '0;
         depth_ff      <= '0;
         err_ff        <= ST_OK;
         fwd_use_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            var_values_ff <= csr_data;
         end
         depth_ff   <= depth_in;
         err_ff     <= err_in;
         fwd_use_ff <= fwd_use_in;
         if (!out_valid_ff || take) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= produce;
            end else begin
               out_valid_ff <= produce;
            end
         end else if (produce) begin
            skid_valid_ff <= 1'b1;
         end
      end
      top_ff     <= top_in;
      fwd_bit_ff <= top_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end else if (produce) begin
         skid_ff <= result;
      end
   end
endmodule

>>> hdl/bfse_checker.sv
// port-level checker for the evaluator top level and its bind
module bfse_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bfse_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bfse_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [bfse_pkg::VAR_W-1:0] csr_data
);
   import bfse_pkg::*;

   logic unused_inputs;
   assign unused_inputs = ^{csr_valid, csr_ready, csr_data};

   // a result beat starts only after a last node beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_data.last))
      else $error("result beat without last node");

   // failed formulas report value zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> !rsp_data.value)
      else $error("nonzero value with error status");

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

   // output buffer empties on reset
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output buffer not cleared by reset");
endmodule

bind boolean_formula_stack_evaluator_top bfse_checker u_bfse_checker (.*);
